[rtl/core/chlg_pkg.sv]
// ----------------------------------------------------------------------------
// chlg_pkg
// Shared types and constants of the core hotplug load governor: controller
// states, controller/datapath command and status bundles, register indexes,
// request codes and arithmetic constants.
// ----------------------------------------------------------------------------
package chlg_pkg;

    localparam int FREQ_W = 22;
    localparam int PCT_W  = 7;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 4;
    localparam int REQ_W  = 2;
    localparam int CIDX_W = 2;
    localparam int REG_W  = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OFFLINE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ONLINE  = 2'd2;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_FREQ_FLOOR     = 3'd0;
    localparam logic [REG_W-1:0] REG_FREQ_CEILING   = 3'd1;
    localparam logic [REG_W-1:0] REG_FREQ_PCT_LOW   = 3'd2;
    localparam logic [REG_W-1:0] REG_FREQ_PCT_HIGH  = 3'd3;
    localparam logic [REG_W-1:0] REG_FREQ_PCT_EXTRA = 3'd4;
    localparam logic [REG_W-1:0] REG_LOAD_PCT_LOW   = 3'd5;
    localparam logic [REG_W-1:0] REG_LOAD_PCT_HIGH  = 3'd6;
    localparam logic [REG_W-1:0] REG_LOAD_PCT_EXTRA = 3'd7;

    // register reset values
    localparam logic [FREQ_W-1:0] RST_FREQ_FLOOR     = 22'd300000;
    localparam logic [FREQ_W-1:0] RST_FREQ_CEILING   = 22'd1400000;
    localparam logic [PCT_W-1:0]  RST_FREQ_PCT_LOW   = 7'd15;
    localparam logic [PCT_W-1:0]  RST_FREQ_PCT_HIGH  = 7'd60;
    localparam logic [PCT_W-1:0]  RST_FREQ_PCT_EXTRA = 7'd80;
    localparam logic [PCT_W-1:0]  RST_LOAD_PCT_LOW   = 7'd15;
    localparam logic [PCT_W-1:0]  RST_LOAD_PCT_HIGH  = 7'd60;
    localparam logic [PCT_W-1:0]  RST_LOAD_PCT_EXTRA = 7'd80;

    // hysteresis
    localparam logic [CNT_W-1:0] LOW_LIMIT  = 4'd10;
    localparam logic [CNT_W-1:0] HIGH_LIMIT = 4'd5;
    localparam logic [CNT_W-1:0] HIGH_STEP  = 4'd5;

    // load divider: one restoring step per cycle; a sample with no idle
    // time at all reaches a full 100 percent
    localparam int               STEP_W     = 7;
    localparam logic [STEP_W-1:0] LOAD_STEPS = 7'd100;
    localparam logic [PCT_W-1:0]  LOAD_PEAK_TOP = 7'd100;

    // span * pct is below 2^29; floor(x / 100) = (x * RECIP_M) >> RECIP_SH
    localparam int               PROD_W   = FREQ_W + PCT_W;
    localparam int               RECIP_W  = 30;
    localparam logic [RECIP_W-1:0] RECIP_M = 30'd687194768;
    localparam int               RECIP_SH = 36;
    localparam int               QUO_W    = 23;
    localparam int               TH_W     = 24;

    // threshold selector
    localparam logic [1:0] TH_LOW   = 2'd0;
    localparam logic [1:0] TH_HIGH  = 2'd1;
    localparam logic [1:0] TH_EXTRA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_ITER,
        ST_PEAK,
        ST_SPAN,
        ST_TH_MUL,
        ST_TH_DIV,
        ST_TH_CMP,
        ST_DECIDE,
        ST_EMIT_ON
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       setup;
        logic       prep;
        logic       iter;
        logic       peak;
        logic       span;
        logic       th_mul;
        logic       th_div;
        logic       th_cmp;
        logic [1:0] th_sel;
        logic       decide;
        logic       emit_on;
    } ctrl_cmd_t;

    typedef struct packed {
        logic enabled;
        logic last;
        logic core_ok;
        logic zero_load;
        logic out_free;
    } ctrl_stat_t;

endpackage

[rtl/core/chlg_ctrl.sv]
// ----------------------------------------------------------------------------
// chlg_ctrl
// Sequencer of the governor: takes a request from the input channel, walks
// the datapath through sample update, the serial load divider, threshold
// evaluation and the hysteresis decision or the bring-online result.
// ----------------------------------------------------------------------------
module chlg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  chlg_pkg::ctrl_stat_t stat,
    output chlg_pkg::ctrl_cmd_t  cmd
);
    import chlg_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [1:0]        sel_reg;
    logic [1:0]        sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sel_reg   <= TH_LOW;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.th_sel = sel_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!stat.enabled)
                begin
                    state_next = stat.last ? ST_EMIT_ON : ST_IDLE;
                end
                else if (stat.core_ok)
                begin
                    cmd.setup  = 1'b1;
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = stat.last ? ST_SPAN : ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                // no busy time: load is zero, skip the divider
                state_next = stat.zero_load ? ST_PEAK : ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LOAD_STEPS - 1'b1)
                begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                cmd.peak   = 1'b1;
                state_next = stat.last ? ST_SPAN : ST_IDLE;
            end
            ST_SPAN:
            begin
                cmd.span   = 1'b1;
                sel_next   = TH_LOW;
                state_next = ST_TH_MUL;
            end
            ST_TH_MUL:
            begin
                cmd.th_mul = 1'b1;
                state_next = ST_TH_DIV;
            end
            ST_TH_DIV:
            begin
                cmd.th_div = 1'b1;
                state_next = ST_TH_CMP;
            end
            ST_TH_CMP:
            begin
                cmd.th_cmp = 1'b1;
                if (sel_reg == TH_EXTRA)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_TH_MUL;
                end
            end
            ST_DECIDE:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_ON:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_on = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_decide_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide || cmd.emit_on) |-> stat.out_free)
        else $error("result written while output register busy");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (step_reg < LOAD_STEPS))
        else $error("load divider step out of range");

    a_last_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TH_CMP && sel_reg == TH_EXTRA) |=> (state_reg == ST_DECIDE))
        else $error("decision not reached after last threshold");
`endif

endmodule

[rtl/core/chlg_dpath.sv]
// ----------------------------------------------------------------------------
// chlg_dpath
// Datapath of the governor: configuration registers, per-core previous
// samples, serial load divider, threshold multiply/reciprocal unit,
// hysteresis counters and the result register.
// ----------------------------------------------------------------------------
module chlg_dpath
#(
    parameter int NUM_CORES = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [chlg_pkg::REG_W-1:0]            cfg_index,
    input  logic [chlg_pkg::FREQ_W-1:0]           cfg_data,
    input  logic [chlg_pkg::CIDX_W-1:0]           core_index,
    input  logic [chlg_pkg::TIME_W-1:0]           idle_total,
    input  logic [chlg_pkg::TIME_W-1:0]           wall_total,
    input  logic [chlg_pkg::FREQ_W-1:0]           freq_now,
    input  logic                                  control_enabled,
    input  logic                                  end_of_tick,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [chlg_pkg::REQ_W-1:0]            request,
    output logic [chlg_pkg::PCT_W-1:0]            peak_load,
    input  chlg_pkg::ctrl_cmd_t                   cmd,
    output chlg_pkg::ctrl_stat_t                  stat
);
    import chlg_pkg::*;

    localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    // configuration
    logic [FREQ_W-1:0] freq_floor_reg;
    logic [FREQ_W-1:0] freq_ceiling_reg;
    logic [PCT_W-1:0]  freq_pct_low_reg;
    logic [PCT_W-1:0]  freq_pct_high_reg;
    logic [PCT_W-1:0]  freq_pct_extra_reg;
    logic [PCT_W-1:0]  load_pct_low_reg;
    logic [PCT_W-1:0]  load_pct_high_reg;
    logic [PCT_W-1:0]  load_pct_extra_reg;

    // captured request
    logic [CIDX_W-1:0] core_reg;
    logic [TIME_W-1:0] idle_reg;
    logic [TIME_W-1:0] wall_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic              enabled_reg;
    logic              last_reg;

    // per-core history
    logic [TIME_W-1:0] last_idle_reg [NUM_CORES];
    logic [TIME_W-1:0] last_wall_reg [NUM_CORES];

    // load divider
    logic [TIME_W-1:0] di_reg;
    logic [TIME_W-1:0] dt_reg;
    logic [TIME_W-1:0] busy_reg;
    logic [TIME_W-1:0] acc_reg;
    logic [PCT_W-1:0]  q_reg;
    logic [PCT_W-1:0]  peak_reg;

    // thresholds
    logic [FREQ_W-1:0]  span_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [2:0]         flag_reg;
    logic [PCT_W-1:0]   pct_sel;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [TH_W-1:0]    th_value;
    logic [TH_W-1:0]    freq_ext;

    // hysteresis and result
    logic [CNT_W-1:0]  low_count_reg;
    logic [CNT_W-1:0]  high_count_reg;
    logic [CNT_W-1:0]  low_count_next;
    logic [CNT_W-1:0]  high_count_next;
    logic [REQ_W-1:0]  request_next;
    logic              out_valid_reg;
    logic [REQ_W-1:0]  request_reg;
    logic [PCT_W-1:0]  peak_out_reg;

    logic [IDX_W-1:0]  idx;

    assign idx = IDX_W'(core_reg);

    assign stat.enabled   = enabled_reg;
    assign stat.last      = last_reg;
    assign stat.core_ok   = (32'(core_reg) < NUM_CORES);
    assign stat.zero_load = (dt_reg <= di_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign request   = request_reg;
    assign peak_load = peak_out_reg;

    always_comb
    begin
        case (cmd.th_sel)
            TH_LOW:   pct_sel = freq_pct_low_reg;
            TH_HIGH:  pct_sel = freq_pct_high_reg;
            TH_EXTRA: pct_sel = freq_pct_extra_reg;
            default:  pct_sel = freq_pct_extra_reg;
        endcase
    end

    assign recip_prod = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_M};
    assign th_value   = TH_W'(freq_floor_reg) + TH_W'(quo_reg);
    assign freq_ext   = TH_W'(freq_reg);

    always_comb
    begin
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        request_next    = REQ_NONE;
        if (peak_reg <= load_pct_low_reg && flag_reg[TH_LOW])
        begin
            low_count_next  = low_count_reg + 1'b1;
            high_count_next = '0;
        end
        else if (peak_reg >= load_pct_extra_reg && flag_reg[TH_EXTRA])
        begin
            low_count_next  = '0;
            high_count_next = high_count_reg + HIGH_STEP;
        end
        else if (peak_reg >= load_pct_high_reg && flag_reg[TH_HIGH])
        begin
            low_count_next  = '0;
            high_count_next = high_count_reg + 1'b1;
        end
        if (low_count_next >= LOW_LIMIT)
        begin
            request_next   = REQ_OFFLINE;
            low_count_next = '0;
        end
        if (high_count_next >= HIGH_LIMIT)
        begin
            request_next    = REQ_ONLINE;
            high_count_next = '0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_floor_reg     <= RST_FREQ_FLOOR;
            freq_ceiling_reg   <= RST_FREQ_CEILING;
            freq_pct_low_reg   <= RST_FREQ_PCT_LOW;
            freq_pct_high_reg  <= RST_FREQ_PCT_HIGH;
            freq_pct_extra_reg <= RST_FREQ_PCT_EXTRA;
            load_pct_low_reg   <= RST_LOAD_PCT_LOW;
            load_pct_high_reg  <= RST_LOAD_PCT_HIGH;
            load_pct_extra_reg <= RST_LOAD_PCT_EXTRA;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FREQ_FLOOR:     freq_floor_reg     <= cfg_data;
                REG_FREQ_CEILING:   freq_ceiling_reg   <= cfg_data;
                REG_FREQ_PCT_LOW:   freq_pct_low_reg   <= cfg_data[PCT_W-1:0];
                REG_FREQ_PCT_HIGH:  freq_pct_high_reg  <= cfg_data[PCT_W-1:0];
                REG_FREQ_PCT_EXTRA: freq_pct_extra_reg <= cfg_data[PCT_W-1:0];
                REG_LOAD_PCT_LOW:   load_pct_low_reg   <= cfg_data[PCT_W-1:0];
                REG_LOAD_PCT_HIGH:  load_pct_high_reg  <= cfg_data[PCT_W-1:0];
                REG_LOAD_PCT_EXTRA: load_pct_extra_reg <= cfg_data[PCT_W-1:0];
                default:            ;
            endcase
        end
    end

    // request capture and working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            core_reg <= core_index;
            idle_reg <= idle_total;
            wall_reg <= wall_total;
            freq_reg <= freq_now;
        end
        if (cmd.setup)
        begin
            di_reg <= idle_reg - last_idle_reg[idx];
            dt_reg <= wall_reg - last_wall_reg[idx];
        end
        if (cmd.prep)
        begin
            busy_reg <= dt_reg - di_reg;
            acc_reg  <= '0;
            q_reg    <= '0;
        end
        else if (cmd.iter)
        begin
            // one step of floor(100 * busy / total); di is total - busy
            if (acc_reg >= di_reg)
            begin
                acc_reg <= acc_reg - di_reg;
                q_reg   <= q_reg + 1'b1;
            end
            else
            begin
                acc_reg <= acc_reg + busy_reg;
            end
        end
        if (cmd.span)
        begin
            span_reg <= (freq_ceiling_reg >= freq_floor_reg) ?
                        (freq_ceiling_reg - freq_floor_reg) : '0;
        end
        if (cmd.th_mul)
        begin
            prod_reg <= PROD_W'(span_reg) * PROD_W'(pct_sel);
        end
        if (cmd.th_div)
        begin
            quo_reg <= recip_prod[RECIP_SH +: QUO_W];
        end
        if (cmd.th_cmp)
        begin
            if (cmd.th_sel == TH_LOW)
            begin
                flag_reg[cmd.th_sel] <= (freq_ext <= th_value);
            end
            else
            begin
                flag_reg[cmd.th_sel] <= (freq_ext >= th_value);
            end
        end
        if (cmd.decide || cmd.emit_on)
        begin
            request_reg  <= cmd.decide ? request_next : REQ_ONLINE;
            peak_out_reg <= cmd.decide ? peak_reg : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            last_reg       <= 1'b0;
            peak_reg       <= '0;
            low_count_reg  <= '0;
            high_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                last_idle_reg[i] <= '0;
                last_wall_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                enabled_reg <= control_enabled;
                last_reg    <= end_of_tick;
            end
            if (cmd.setup)
            begin
                last_idle_reg[idx] <= idle_reg;
                last_wall_reg[idx] <= wall_reg;
            end
            if (cmd.peak && q_reg > peak_reg)
            begin
                peak_reg <= q_reg;
            end
            if (cmd.decide)
            begin
                low_count_reg  <= low_count_next;
                high_count_reg <= high_count_next;
            end
            if (cmd.decide || cmd.emit_on)
            begin
                peak_reg      <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        low_count_reg < LOW_LIMIT)
        else $error("low counter reached its limit without a request");

    a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_count_reg < HIGH_LIMIT)
        else $error("high counter reached its limit without a request");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= LOAD_PEAK_TOP)
        else $error("peak load above 100 percent");
`endif

endmodule

[rtl/core/core_hotplug_load_governor_unit.sv]
// ----------------------------------------------------------------------------
// core_hotplug_load_governor_unit
// Per-tick core load tracking and hotplug request generation.
// ----------------------------------------------------------------------------
// One request at a time. A sample from an enabled, in-range core passes
// through capture, delta, prepare, 100 steps of the serial load divider and
// peak update; the divider retires one step of the 100-step percent
// computation per cycle. When the idle delta covers the wall delta the load
// is zero and the divider is skipped. The last sample of a tick adds the
// range, three threshold evaluations through one shared multiply and
// reciprocal unit, and the decision; the decision waits while an earlier
// result is still held in the output register, and the new result then sits
// there while the next sample is taken. Samples with control disabled or an
// out-of-range core index are only captured and checked; as a tick's last
// sample they add the range, threshold evaluations and decision for an
// out-of-range core, or the bring-online result when control is disabled.
// The configuration port never stalls; write registers only while the block
// is idle.
module core_hotplug_load_governor_unit
#(
    parameter int NUM_CORES = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [chlg_pkg::REG_W-1:0]        cfg_index,
    input  logic [chlg_pkg::FREQ_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [chlg_pkg::CIDX_W-1:0]       core_index,
    input  logic [chlg_pkg::TIME_W-1:0]       idle_total,
    input  logic [chlg_pkg::TIME_W-1:0]       wall_total,
    input  logic [chlg_pkg::FREQ_W-1:0]       freq_now,
    input  logic                              control_enabled,
    input  logic                              end_of_tick,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [chlg_pkg::REQ_W-1:0]        request,
    output logic [chlg_pkg::PCT_W-1:0]        peak_load
);
    import chlg_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    chlg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    chlg_dpath
    #(
        .NUM_CORES (NUM_CORES)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .core_index      (core_index),
        .idle_total      (idle_total),
        .wall_total      (wall_total),
        .freq_now        (freq_now),
        .control_enabled (control_enabled),
        .end_of_tick     (end_of_tick),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .request         (request),
        .peak_load       (peak_load),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the core hotplug load governor. Feeds polling
// ticks of per-core idle/wall totals under several register settings,
// predicts every tick's hotplug request and peak load in the bench, and
// compares each returned result with the oldest prediction, while the input
// side pauses in bursts and the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
import chlg_pkg::*;

localparam int CORE_COUNT = 4;

typedef struct {
    logic [REQ_W-1:0] req;
    logic [PCT_W-1:0] peak;
} tick_decision_t;

class tick_decision_checker;
    logic [FREQ_W-1:0] floor_khz;
    logic [FREQ_W-1:0] ceil_khz;
    logic [PCT_W-1:0]  fpct_lo;
    logic [PCT_W-1:0]  fpct_hi;
    logic [PCT_W-1:0]  fpct_xh;
    logic [PCT_W-1:0]  lpct_lo;
    logic [PCT_W-1:0]  lpct_hi;
    logic [PCT_W-1:0]  lpct_xh;
    logic [TIME_W-1:0] hist_idle [CORE_COUNT];
    logic [TIME_W-1:0] hist_wall [CORE_COUNT];
    logic [CNT_W-1:0]  idle_ticks;
    logic [CNT_W-1:0]  busy_ticks;
    logic [PCT_W-1:0]  tick_peak;
    tick_decision_t    pending_decisions[$];
    int                errors;

    function new();
        floor_khz = RST_FREQ_FLOOR;
        ceil_khz  = RST_FREQ_CEILING;
        fpct_lo   = RST_FREQ_PCT_LOW;
        fpct_hi   = RST_FREQ_PCT_HIGH;
        fpct_xh   = RST_FREQ_PCT_EXTRA;
        lpct_lo   = RST_LOAD_PCT_LOW;
        lpct_hi   = RST_LOAD_PCT_HIGH;
        lpct_xh   = RST_LOAD_PCT_EXTRA;
        foreach (hist_idle[i])
        begin
            hist_idle[i] = '0;
            hist_wall[i] = '0;
        end
        idle_ticks = '0;
        busy_ticks = '0;
        tick_peak  = '0;
        errors     = 0;
    endfunction

    function void set_register(logic [REG_W-1:0] idx, logic [FREQ_W-1:0] data);
        case (idx)
            REG_FREQ_FLOOR:     floor_khz = data;
            REG_FREQ_CEILING:   ceil_khz  = data;
            REG_FREQ_PCT_LOW:   fpct_lo   = data[PCT_W-1:0];
            REG_FREQ_PCT_HIGH:  fpct_hi   = data[PCT_W-1:0];
            REG_FREQ_PCT_EXTRA: fpct_xh   = data[PCT_W-1:0];
            REG_LOAD_PCT_LOW:   lpct_lo   = data[PCT_W-1:0];
            REG_LOAD_PCT_HIGH:  lpct_hi   = data[PCT_W-1:0];
            default:            lpct_xh   = data[PCT_W-1:0];
        endcase
    endfunction

    // floor + floor(span * pct / 100); an inverted range collapses to the floor
    function logic [63:0] threshold(logic [PCT_W-1:0] pct);
        logic [63:0] range_khz;
        range_khz = (ceil_khz >= floor_khz) ? 64'(ceil_khz - floor_khz) : 64'd0;
        return 64'(floor_khz) + (range_khz * 64'(pct)) / 64'd100;
    endfunction

    function logic [PCT_W-1:0] load_percent(logic [TIME_W-1:0] busy, logic [TIME_W-1:0] total);
        logic [71:0] scaled;
        scaled = 72'(busy) * 72'd100;
        return PCT_W'(scaled / 72'(total));
    endfunction

    function void take_sample(logic [CIDX_W-1:0] core, logic [TIME_W-1:0] idle,
                              logic [TIME_W-1:0] wall, logic [FREQ_W-1:0] freq,
                              logic en, logic last);
        logic [TIME_W-1:0] di;
        logic [TIME_W-1:0] dt;
        logic [PCT_W-1:0]  load;
        logic [63:0]       freq64;
        int                lo_n;
        int                hi_n;
        tick_decision_t    d;
        if (!en)
        begin
            if (last)
            begin
                tick_peak = '0;
                d.req = REQ_ONLINE;
                d.peak = '0;
                pending_decisions.push_back(d);
            end
            return;
        end
        if (int'(core) < CORE_COUNT)
        begin
            di = idle - hist_idle[core];
            dt = wall - hist_wall[core];
            load = (dt <= di) ? '0 : load_percent(dt - di, dt);
            hist_idle[core] = idle;
            hist_wall[core] = wall;
            if (load > tick_peak)
                tick_peak = load;
        end
        if (!last)
            return;
        freq64 = 64'(freq);
        lo_n = int'(idle_ticks);
        hi_n = int'(busy_ticks);
        if (tick_peak <= lpct_lo && freq64 <= threshold(fpct_lo))
        begin
            lo_n++;
            hi_n = 0;
        end
        else if (tick_peak >= lpct_xh && freq64 >= threshold(fpct_xh))
        begin
            lo_n = 0;
            hi_n += int'(HIGH_STEP);
        end
        else if (tick_peak >= lpct_hi && freq64 >= threshold(fpct_hi))
        begin
            lo_n = 0;
            hi_n++;
        end
        d.req = REQ_NONE;
        if (lo_n >= int'(LOW_LIMIT))
        begin
            d.req = REQ_OFFLINE;
            lo_n = 0;
        end
        if (hi_n >= int'(HIGH_LIMIT))
        begin
            d.req = REQ_ONLINE;
            hi_n = 0;
        end
        idle_ticks = CNT_W'(lo_n);
        busy_ticks = CNT_W'(hi_n);
        d.peak = tick_peak;
        tick_peak = '0;
        pending_decisions.push_back(d);
    endfunction

    function void match_decision(logic [REQ_W-1:0] req, logic [PCT_W-1:0] peak);
        tick_decision_t d;
        if (pending_decisions.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, request %0d peak_load %0d", $time, req, peak);
            return;
        end
        d = pending_decisions.pop_front();
        if (req !== d.req)
        begin
            errors++;
            $display("%0t: request mismatch, expected %0d, actual %0d", $time, d.req, req);
        end
        if (peak !== d.peak)
        begin
            errors++;
            $display("%0t: peak_load mismatch, expected %0d, actual %0d",
                     $time, d.peak, peak);
        end
    endfunction
endclass

module tb;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD     = 3000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum int { TREND_IDLE, TREND_BUSY, TREND_SURGE, TREND_MIXED } trend_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [REG_W-1:0]    cfg_index;
    logic [FREQ_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [CIDX_W-1:0]   core_index;
    logic [TIME_W-1:0]   idle_total;
    logic [TIME_W-1:0]   wall_total;
    logic [FREQ_W-1:0]   freq_now;
    logic                control_enabled;
    logic                end_of_tick;
    logic                out_valid;
    logic                out_stall;
    logic [REQ_W-1:0]    request;
    logic [PCT_W-1:0]    peak_load;

    tick_decision_checker decisions = new();

    logic [TIME_W-1:0] shadow_idle [CORE_COUNT];
    logic [TIME_W-1:0] shadow_wall [CORE_COUNT];
    int                burst_left = 0;
    int                offered    = 0;
    int                cycles     = 0;
    bit                hold_off_req = 1'b0;

    core_hotplug_load_governor_unit #(.NUM_CORES(CORE_COUNT)) uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                decisions.match_decision(request, peak_load);
            if (in_valid && !in_stall)
                decisions.take_sample(core_index, idle_total, wall_total, freq_now,
                                      control_enabled, end_of_tick);
        end
    end

    // receiver: segments of free flow, light and heavy stalling, one long hold
    initial
    begin
        int seg_len;
        int mode;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            seg_len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic offer_sample(input logic [CIDX_W-1:0] core, input logic [TIME_W-1:0] idle,
                                input logic [TIME_W-1:0] wall, input logic [FREQ_W-1:0] freq,
                                input logic en, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 200);
                default: gap = $urandom_range(1, 30);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        core_index      <= core;
        idle_total      <= idle;
        wall_total      <= wall;
        freq_now        <= freq;
        control_enabled <= en;
        end_of_tick     <= last;
        in_valid        <= 1'b1;
        shadow_idle[core] = idle;
        shadow_wall[core] = wall;
        offered++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // hold until every decision is back and the block has finished any sample
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        // let the monitor note the request accepted at the last edge
        @(posedge clk);
        while (decisions.pending_decisions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [FREQ_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        decisions.set_register(idx, data);
    endtask

    task automatic configure(input int kind);
        logic [FREQ_W-1:0] vals [8];
        int a;
        int b;
        case (kind)
            0:
            begin
                vals[REG_FREQ_FLOOR]   = FREQ_W'($urandom_range(0, 2000000));
                vals[REG_FREQ_CEILING] = FREQ_W'($urandom_range(vals[REG_FREQ_FLOOR],
                                                                FREQ_MAX));
                a = $urandom_range(0, 40);
                b = $urandom_range(a, 90);
                vals[REG_FREQ_PCT_LOW]   = FREQ_W'(a);
                vals[REG_FREQ_PCT_HIGH]  = FREQ_W'(b);
                vals[REG_FREQ_PCT_EXTRA] = FREQ_W'($urandom_range(b, 100));
                a = $urandom_range(0, 40);
                b = $urandom_range(a, 90);
                vals[REG_LOAD_PCT_LOW]   = FREQ_W'(a);
                vals[REG_LOAD_PCT_HIGH]  = FREQ_W'(b);
                vals[REG_LOAD_PCT_EXTRA] = FREQ_W'($urandom_range(b, 100));
            end
            1:
            begin
                vals[REG_FREQ_FLOOR]     = '0;
                vals[REG_FREQ_CEILING]   = FREQ_MAX;
                vals[REG_FREQ_PCT_LOW]   = '0;
                vals[REG_FREQ_PCT_HIGH]  = FREQ_W'(100);
                vals[REG_FREQ_PCT_EXTRA] = FREQ_W'(100);
                vals[REG_LOAD_PCT_LOW]   = '0;
                vals[REG_LOAD_PCT_HIGH]  = FREQ_W'(100);
                vals[REG_LOAD_PCT_EXTRA] = FREQ_W'(100);
            end
            2:
            begin
                // inverted range, percents with junk above bit 6
                vals[REG_FREQ_FLOOR]     = FREQ_W'($urandom_range(1000000, FREQ_MAX));
                vals[REG_FREQ_CEILING]   = FREQ_W'($urandom_range(0,
                                                   vals[REG_FREQ_FLOOR] - 1));
                vals[REG_FREQ_PCT_LOW]   = {15'($urandom), 7'($urandom_range(0, 127))};
                vals[REG_FREQ_PCT_HIGH]  = {15'($urandom), 7'd127};
                vals[REG_FREQ_PCT_EXTRA] = {15'($urandom), 7'($urandom_range(0, 127))};
                vals[REG_LOAD_PCT_LOW]   = {15'($urandom), 7'($urandom_range(0, 30))};
                vals[REG_LOAD_PCT_HIGH]  = {15'($urandom), 7'($urandom_range(30, 100))};
                vals[REG_LOAD_PCT_EXTRA] = {15'($urandom), 7'($urandom_range(50, 127))};
            end
            3:
            begin
                vals[REG_FREQ_FLOOR]     = RST_FREQ_FLOOR;
                vals[REG_FREQ_CEILING]   = RST_FREQ_CEILING;
                vals[REG_FREQ_PCT_LOW]   = {15'($urandom), 7'($urandom_range(0, 100))};
                vals[REG_FREQ_PCT_HIGH]  = {15'($urandom), 7'($urandom_range(0, 100))};
                vals[REG_FREQ_PCT_EXTRA] = {15'($urandom), 7'($urandom_range(0, 100))};
                vals[REG_LOAD_PCT_LOW]   = {15'($urandom), 7'($urandom_range(101, 127))};
                vals[REG_LOAD_PCT_HIGH]  = {15'($urandom), 7'd0};
                vals[REG_LOAD_PCT_EXTRA] = {15'($urandom), 7'd0};
            end
            4:
            begin
                vals[REG_FREQ_FLOOR]     = RST_FREQ_FLOOR;
                vals[REG_FREQ_CEILING]   = RST_FREQ_CEILING;
                vals[REG_FREQ_PCT_LOW]   = FREQ_W'(RST_FREQ_PCT_LOW);
                vals[REG_FREQ_PCT_HIGH]  = FREQ_W'(RST_FREQ_PCT_HIGH);
                vals[REG_FREQ_PCT_EXTRA] = FREQ_W'(RST_FREQ_PCT_EXTRA);
                vals[REG_LOAD_PCT_LOW]   = FREQ_W'(RST_LOAD_PCT_LOW);
                vals[REG_LOAD_PCT_HIGH]  = FREQ_W'(RST_LOAD_PCT_HIGH);
                vals[REG_LOAD_PCT_EXTRA] = FREQ_W'(RST_LOAD_PCT_EXTRA);
            end
            default:
            begin
                foreach (vals[i])
                    vals[i] = FREQ_W'($urandom);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(REG_W'(i), vals[i]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FREQ_W-1:0] clamp_freq(logic [63:0] v);
        return (v > 64'(FREQ_MAX)) ? FREQ_MAX : v[FREQ_W-1:0];
    endfunction

    function automatic int unsigned pick_load(trend_t t);
        int unsigned lo;
        int unsigned hi;
        int unsigned xh;
        lo = (decisions.lpct_lo > 100) ? 100 : decisions.lpct_lo;
        hi = (decisions.lpct_hi > 100) ? 100 : decisions.lpct_hi;
        xh = (decisions.lpct_xh > 100) ? 100 : decisions.lpct_xh;
        case (t)
            TREND_IDLE:  return $urandom_range(0, lo);
            TREND_BUSY:  return $urandom_range(hi, 100);
            TREND_SURGE: return $urandom_range(xh, 100);
            default:     return $urandom_range(0, 100);
        endcase
    endfunction

    // aim at, just past, or well beyond the threshold that the trend tests
    function automatic logic [FREQ_W-1:0] pick_freq(trend_t t);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] xh;
        int          r;
        lo = decisions.threshold(decisions.fpct_lo);
        hi = decisions.threshold(decisions.fpct_hi);
        xh = decisions.threshold(decisions.fpct_xh);
        r = $urandom_range(0, 3);
        case (t)
            TREND_IDLE:
                case (r)
                    0:       return clamp_freq(lo);
                    1:       return clamp_freq(64'(decisions.floor_khz));
                    2:       return FREQ_W'($urandom_range(0, clamp_freq(lo)));
                    default: return clamp_freq(lo + 1);
                endcase
            TREND_BUSY:
                case (r)
                    0:       return clamp_freq(hi);
                    1:       return clamp_freq(hi - 1);
                    default: return FREQ_W'($urandom_range(clamp_freq(hi), FREQ_MAX));
                endcase
            TREND_SURGE:
                case (r)
                    0:       return clamp_freq(xh);
                    1:       return FREQ_MAX;
                    2:       return clamp_freq(xh - 1);
                    default: return FREQ_W'($urandom_range(clamp_freq(xh), FREQ_MAX));
                endcase
            default:
                case (r)
                    0:       return FREQ_W'($urandom);
                    1:       return '0;
                    2:       return clamp_freq(hi + 1);
                    default: return clamp_freq(xh);
                endcase
        endcase
    endfunction

    // one polling tick: distinct cores with advancing totals, last one ends it
    task automatic run_tick(input trend_t t);
        int                n;
        int                base_core;
        int unsigned       tgt;
        logic [CIDX_W-1:0] c;
        logic [TIME_W-1:0] m;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] di;
        logic              en;
        n = $urandom_range(1, CORE_COUNT);
        base_core = $urandom_range(0, CORE_COUNT - 1);
        for (int k = 0; k < n; k++)
        begin
            c = CIDX_W'((base_core + k) % CORE_COUNT);
            tgt = pick_load(t);
            if ($urandom_range(0, 15) == 0)
                m = 64'($urandom) * 64'd1000 + 64'd1;
            else
                m = 64'($urandom_range(1, 1 << 20));
            dt = m * 64'd100;
            di = dt - m * 64'(tgt);
            if (t == TREND_MIXED && $urandom_range(0, 7) == 0)
                di = dt + 64'($urandom_range(0, 5000));
            en = ($urandom_range(0, 24) != 0);
            offer_sample(c, shadow_idle[c] + di, shadow_wall[c] + dt, pick_freq(t), en,
                         k == n - 1);
        end
    endtask

    task automatic run_phase(input int kind, input int count);
        int     stop;
        int     runs;
        trend_t t;
        configure(kind);
        stop = offered + count;
        while (offered < stop)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                // raw totals and flags: wrapping, disabled samples, loose tick ends
                offer_sample(CIDX_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                             FREQ_W'($urandom), $urandom_range(0, 3) != 0,
                             $urandom_range(0, 1) == 1);
            end
            else
            begin
                t = trend_t'($urandom_range(0, 3));
                runs = $urandom_range(1, 12);
                repeat (runs) run_tick(t);
            end
        end
        run_tick(TREND_MIXED);
        drain_results();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_FREQ_FLOOR;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        core_index      <= '0;
        idle_total      <= '0;
        wall_total      <= '0;
        freq_now        <= '0;
        control_enabled <= 1'b0;
        end_of_tick     <= 1'b0;
        foreach (shadow_idle[i])
        begin
            shadow_idle[i] = '0;
            shadow_wall[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero deltas at low frequency: first idle tick
        offer_sample(2'd0, '0, '0, '0, 1'b1, 1'b1);
        offer_sample(2'd1, '0, 64'd1000, FREQ_MAX, 1'b1, 1'b0);
        // idle delta equal to wall delta
        offer_sample(2'd2, TIME_MAX, TIME_MAX, 22'h2AAAAA, 1'b1, 1'b0);
        // fully busy at top frequency: busy count jumps to its limit
        offer_sample(2'd3, '0, TIME_MAX, FREQ_MAX, 1'b1, 1'b1);
        offer_sample(2'd1, 64'd500, 64'd1000, 22'h155555, 1'b1, 1'b0);
        offer_sample(2'd0, TIME_MAX - 9, TIME_MAX - 7, '0, 1'b1, 1'b0);
        // totals wrap through zero
        offer_sample(2'd0, 64'd3, 64'd40, '0, 1'b1, 1'b1);
        // control off: sample dropped, tick end forces bring-online
        offer_sample(2'd2, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, FREQ_MAX,
                     1'b0, 1'b0);
        offer_sample(2'd3, '0, '0, '0, 1'b0, 1'b1);
        // load exactly at the busy limit, frequency exactly at the high threshold
        offer_sample(2'd1, 64'd540, 64'd1100, 22'd960000, 1'b1, 1'b1);
        // load exactly at the very busy limit, frequency at the very high threshold
        offer_sample(2'd2, 64'd19, 64'd99, 22'd1180000, 1'b1, 1'b1);
        // ten idle ticks at the low threshold: take a core offline
        repeat (10)
            offer_sample(2'd3, shadow_idle[3] + 64'd1000, shadow_wall[3] + 64'd1000,
                         22'd465000, 1'b1, 1'b1);
        drain_results();

        hold_off_req = 1'b1;
        run_phase(0, 85);
        run_phase(1, 85);
        run_phase(2, 80);
        run_phase(3, 80);
        run_phase(5, 85);
        run_phase(4, 85);

        if (decisions.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
